FILE: src/vdrle_pkg.sv
// ----------------------------------------------------------------------------
// vdrle_pkg
// Shared types and constants of the variable-depth run-length unpacker.
// ----------------------------------------------------------------------------
package vdrle_pkg;

	localparam int unsigned CountW = 17;
	localparam logic [CountW-1:0] MaxSamples = CountW'(65536);

	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoAw = $clog2(FifoDepth);

	localparam logic [7:0] NoopControl = 8'h80;
	localparam logic [7:0] LiteralMax = 8'h7F;
	localparam logic [8:0] RepeatBase = 9'd257;

	localparam logic [3:0] DepthMax = 4'd8;

	localparam logic [1:0] CfgSampleDepth = 2'd0;
	localparam logic [1:0] CfgOutputCount = 2'd1;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StOverflow = 2'd1;
	localparam logic [1:0] StTruncated = 2'd2;

	typedef enum logic [2:0] {
		PH_CONTROL = 3'b001,
		PH_LITERAL = 3'b010,
		PH_REPEAT = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic source_end;
	} item_t;

	typedef struct packed {
		logic [7:0] sample_value;
		logic [7:0] repeat_count;
		logic final_result;
		logic [1:0] status;
	} run_t;

endpackage

FILE: src/vdrle_front.sv
// ----------------------------------------------------------------------------
// vdrle_front
// Input side: takes compressed words and queues them for the decode engine.
// ----------------------------------------------------------------------------
module vdrle_front import vdrle_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input item_t push_item,
	output logic pop_valid,
	input logic pop_ready,
	output item_t pop_item
);

	item_t mem_q [FifoDepth];
	logic [FifoAw-1:0] wr_q;
	logic [FifoAw-1:0] rd_q;
	logic [FifoAw:0] cnt_q;
	logic push;
	logic pop;

	assign push_ready = (cnt_q != (FifoAw+1)'(FifoDepth));
	assign pop_valid = (cnt_q != '0);
	assign pop_item = mem_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: src/vdrle_back.sv
// ----------------------------------------------------------------------------
// vdrle_back
// Decode engine: cuts one field per cycle out of the bit window unless a held
// result has nowhere to go, tracks the run state and drives the result register.
// ----------------------------------------------------------------------------
module vdrle_back import vdrle_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [3:0] depth,
	input logic [CountW-1:0] count,
	input logic q_valid,
	output logic q_ready,
	input item_t q_item,
	output logic run_valid,
	input logic run_ready,
	output run_t run
);

	logic busy_q;
	logic [14:0] acc_q;
	logic [3:0] total_q;
	logic last_q;
	phase_t phase_q;
	logic [7:0] lit_left_q;
	logic [7:0] pend_q;
	logic [CountW-1:0] written_q;
	logic fin_q;
	logic run_valid_q;
	run_t run_q;

	logic slot_free;
	logic is_ctrl;
	logic [3:0] need;
	logic fin_now;
	logic end_step;
	logic field_step;
	logic [3:0] sh;
	logic [14:0] shifted;
	logic [7:0] mask8;
	logic [7:0] field;
	logic is_noop;
	logic is_lit;
	logic [7:0] run_len;
	logic overflow;
	logic [7:0] cnt;
	logic [CountW-1:0] written_new;
	logic samp_fin;
	logic trunc_need;
	logic emit;
	run_t emit_run;
	logic advance;
	logic drop_bits;
	logic [7:0] mask_keep;
	logic [6:0] acc_keep;
	logic [3:0] total_keep;
	logic [6:0] src_acc;
	logic [3:0] src_tot;
	logic load;

	always_comb begin
		slot_free = !run_valid_q || run_ready;
		is_ctrl = (phase_q == PH_CONTROL);
		need = is_ctrl ? 4'd8 : depth;
		fin_now = fin_q || (is_ctrl && (written_q >= count));
		end_step = busy_q && (fin_now || (total_q < need));
		field_step = busy_q && !end_step;

		sh = total_q - need;
		shifted = acc_q >> sh;
		mask8 = 8'hFF >> (4'd8 - need);
		field = shifted[7:0] & mask8;

		is_noop = (field == NoopControl);
		is_lit = (field <= LiteralMax);
		run_len = is_lit ? (field + 8'd1) : 8'(RepeatBase - {1'b0, field});
		overflow = ({1'b0, written_q} + (CountW+1)'(run_len)) > {1'b0, count};

		cnt = (phase_q == PH_LITERAL) ? 8'd1 : pend_q;
		written_new = written_q + CountW'(cnt);
		samp_fin = (written_new >= count);

		trunc_need = last_q && !fin_now && (written_q < count);

		emit = 1'b0;
		emit_run = '0;
		if (field_step && is_ctrl && !is_noop && overflow) begin
			emit = 1'b1;
			emit_run = '{sample_value: 8'd0, repeat_count: 8'd0,
				final_result: 1'b1, status: StOverflow};
		end else if (field_step && !is_ctrl) begin
			emit = 1'b1;
			emit_run = '{sample_value: field, repeat_count: cnt,
				final_result: samp_fin, status: StOk};
		end else if (end_step && trunc_need) begin
			emit = 1'b1;
			emit_run = '{sample_value: 8'd0, repeat_count: 8'd0,
				final_result: 1'b1, status: StTruncated};
		end

		// stall the engine only when a result has nowhere to go
		advance = busy_q && (!emit || slot_free);

		// leftover bits carry over unless the image is done or the source ends
		drop_bits = last_q || fin_now;
		mask_keep = (8'd1 << total_q[2:0]) - 8'd1;
		acc_keep = drop_bits ? 7'd0 : (acc_q[6:0] & mask_keep[6:0]);
		total_keep = drop_bits ? 4'd0 : total_q;
		src_acc = busy_q ? acc_keep : acc_q[6:0];
		src_tot = busy_q ? total_keep : total_q;

		q_ready = !busy_q || (end_step && advance);
		load = q_valid && q_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			acc_q <= '0;
			total_q <= '0;
			last_q <= 1'b0;
			phase_q <= PH_CONTROL;
			lit_left_q <= '0;
			pend_q <= '0;
			written_q <= '0;
			fin_q <= 1'b0;
		end else begin
			if (advance && field_step) begin
				total_q <= sh;
				if (is_ctrl) begin
					if (!is_noop) begin
						if (overflow) begin
							fin_q <= 1'b1;
						end else if (is_lit) begin
							lit_left_q <= run_len;
							phase_q <= PH_LITERAL;
						end else begin
							pend_q <= run_len;
							phase_q <= PH_REPEAT;
						end
					end
				end else begin
					written_q <= written_new;
					if (phase_q == PH_LITERAL) begin
						lit_left_q <= lit_left_q - 8'd1;
						if (lit_left_q == 8'd1) begin
							phase_q <= PH_CONTROL;
						end
					end else begin
						pend_q <= 8'd0;
						phase_q <= PH_CONTROL;
					end
					if (samp_fin) begin
						fin_q <= 1'b1;
					end
				end
			end
			if (advance && end_step) begin
				busy_q <= 1'b0;
				acc_q <= {8'd0, acc_keep};
				total_q <= total_keep;
				fin_q <= fin_now;
				if (last_q) begin
					phase_q <= PH_CONTROL;
					lit_left_q <= '0;
					pend_q <= '0;
					written_q <= '0;
					fin_q <= 1'b0;
				end
			end
			// a new word joins the leftover bits in the same cycle
			if (load) begin
				busy_q <= 1'b1;
				acc_q <= {src_acc, q_item.stream_byte};
				total_q <= src_tot + 4'd8;
				last_q <= q_item.source_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
		end else if (slot_free) begin
			run_valid_q <= busy_q && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && busy_q && emit) begin
			run_q <= emit_run;
		end
	end

	assign run_valid = run_valid_q;
	assign run = run_q;

endmodule

FILE: src/variable_depth_rle_unpacker.sv
// ----------------------------------------------------------------------------
// variable_depth_rle_unpacker
// A word passes through the input queue before the decode engine loads it;
// each result is registered in the output register as its field is decoded.
// The engine cuts one field per cycle unless a held result has nowhere to go,
// and closes each word with an end step in which it can take the next word.
// Reset: asynchronous; depth 8, count 65536, stream state and queue cleared.
// ----------------------------------------------------------------------------
module variable_depth_rle_unpacker import vdrle_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input item_t item,
	output logic run_valid,
	input logic run_ready,
	output run_t run,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [CountW-1:0] cfg_data
);

	logic [3:0] depth_q;
	logic [CountW-1:0] count_q;
	logic [3:0] eff_depth;
	logic [CountW-1:0] eff_count;
	logic q_valid;
	logic q_ready;
	item_t q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DepthMax;
			count_q <= MaxSamples;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CfgSampleDepth: depth_q <= cfg_data[3:0];
				CfgOutputCount: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// out-of-range depth falls back to 8, count clamps to the sample limit
	assign eff_depth = ((depth_q == 4'd0) || (depth_q > DepthMax)) ? DepthMax : depth_q;
	assign eff_count = (count_q > MaxSamples) ? MaxSamples : count_q;

	vdrle_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(item_valid),
		.push_ready(item_ready),
		.push_item(item),
		.pop_valid(q_valid),
		.pop_ready(q_ready),
		.pop_item(q_item)
	);

	vdrle_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.depth(eff_depth),
		.count(eff_count),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item),
		.run_valid(run_valid),
		.run_ready(run_ready),
		.run(run)
	);

endmodule

FILE: bench/rle_run_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_run_checker
// Watches the word, run and register channels of the unpacker, decodes every
// accepted word on its own copy of the stream state and compares each
// accepted run field by field with the oldest run still owed.
// ----------------------------------------------------------------------------
module rle_run_checker import vdrle_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input item_t item,
	input logic run_valid,
	input logic run_ready,
	input run_t run,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [CountW-1:0] cfg_data,
	output int mismatches,
	output int runs_owed
);

	logic [3:0] depth_cfg;
	logic [CountW-1:0] count_cfg;

	logic [7:0] spill;
	logic [3:0] spill_bits;
	phase_t phase;
	logic [7:0] literal_owed;
	logic [7:0] repeat_len;
	logic [CountW-1:0] produced;
	logic halted;

	run_t expected_runs[$];

	function automatic void clear_stream();
		spill = '0;
		spill_bits = '0;
		phase = PH_CONTROL;
		literal_owed = '0;
		repeat_len = '0;
		produced = '0;
		halted = 1'b0;
	endfunction

	function automatic void owe_run(input int val, input int cnt, input int fin, input int st);
		run_t r;
		r.sample_value = val[7:0];
		r.repeat_count = cnt[7:0];
		r.final_result = fin[0];
		r.status = st[1:0];
		expected_runs.push_back(r);
	endfunction

	function automatic void decode_word(input item_t w);
		int depth, cap, acc, total, need, fld, left, len, cnt;
		depth = (depth_cfg == 0 || depth_cfg > DepthMax) ? DepthMax : depth_cfg;
		cap = (count_cfg > MaxSamples) ? MaxSamples : count_cfg;
		if (!halted) begin
			acc = {spill, w.stream_byte};
			total = spill_bits + 8;
			while (!halted) begin
				// a control is due with the count already met: stop silently
				if (phase == PH_CONTROL && produced >= cap) begin
					halted = 1'b1;
					break;
				end
				need = (phase == PH_CONTROL) ? 8 : depth;
				if (total < need)
					break;
				fld = (acc >> (total - need)) & ((1 << need) - 1);
				total -= need;
				left = cap - produced;
				if (phase == PH_CONTROL) begin
					if (fld == NoopControl)
						continue;
					len = (fld <= LiteralMax) ? fld + 1 : RepeatBase - fld;
					if (len > left) begin
						owe_run(0, 0, 1, StOverflow);
						halted = 1'b1;
						break;
					end
					if (fld <= LiteralMax) begin
						literal_owed = 8'(len);
						phase = PH_LITERAL;
					end else begin
						repeat_len = 8'(len);
						phase = PH_REPEAT;
					end
				end else begin
					cnt = (phase == PH_LITERAL) ? 1 : repeat_len;
					produced = produced + CountW'(cnt);
					owe_run(fld, cnt, produced >= cap, StOk);
					if (phase == PH_LITERAL) begin
						literal_owed = literal_owed - 8'd1;
						if (literal_owed == 0)
							phase = PH_CONTROL;
					end else begin
						repeat_len = '0;
						phase = PH_CONTROL;
					end
					if (produced >= cap)
						halted = 1'b1;
				end
			end
			if (halted) begin
				spill = '0;
				spill_bits = '0;
			end else begin
				spill_bits = 4'(total);
				spill = 8'(acc & ((1 << total) - 1));
			end
		end
		if (w.source_end) begin
			if (!halted && produced < cap)
				owe_run(0, 0, 1, StTruncated);
			clear_stream();
		end
	endfunction

	function automatic void check_run(input run_t got);
		run_t want;
		if (expected_runs.size() == 0) begin
			$error("unexpected run: sample_value %0d repeat_count %0d final_result %0d status %0d",
				got.sample_value, got.repeat_count, got.final_result, got.status);
			mismatches++;
			return;
		end
		want = expected_runs.pop_front();
		if (got.sample_value !== want.sample_value) begin
			$error("sample_value: expected %0d, got %0d", want.sample_value, got.sample_value);
			mismatches++;
		end
		if (got.repeat_count !== want.repeat_count) begin
			$error("repeat_count: expected %0d, got %0d", want.repeat_count, got.repeat_count);
			mismatches++;
		end
		if (got.final_result !== want.final_result) begin
			$error("final_result: expected %0d, got %0d", want.final_result, got.final_result);
			mismatches++;
		end
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_cfg = DepthMax;
			count_cfg = MaxSamples;
			clear_stream();
			expected_runs.delete();
			runs_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CfgSampleDepth)
					depth_cfg = cfg_data[3:0];
				else if (cfg_index == CfgOutputCount)
					count_cfg = cfg_data;
			end
			if (item_valid && item_ready)
				decode_word(item);
			if (run_valid && run_ready)
				check_run(run);
			runs_owed <= expected_runs.size();
		end
	end

endmodule

FILE: bench/variable_depth_rle_unpacker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// variable_depth_rle_unpacker_tb
// Feeds bit-packed run-length images at many depths and counts: a directed
// opening, then well-formed images with random content mixed with overflow,
// truncated and noise streams, with random stalls on both channels.
// ----------------------------------------------------------------------------
module variable_depth_rle_unpacker_tb;
	import vdrle_pkg::*;

	localparam logic [1:0] CfgSpareA = 2'd2;
	localparam logic [1:0] CfgSpareB = 2'd3;
	localparam int RandomWords = 230;
	localparam int DrainCycles = 60;

	typedef enum {IMG_CLEAN, IMG_OVERFLOW, IMG_SHORT, IMG_NOISE} image_kind_t;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic run_valid;
	logic run_ready = 1'b0;
	run_t run;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CfgSampleDepth;
	logic [CountW-1:0] cfg_data = '0;

	int mismatches;
	int runs_owed;
	bit steady = 1'b0;
	bit sender_calm = 1'b0;
	bit stream_bits[$];
	int words_sent = 0;

	variable_depth_rle_unpacker dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.run_valid(run_valid),
		.run_ready(run_ready),
		.run(run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rle_run_checker runs_check (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.run_valid(run_valid),
		.run_ready(run_ready),
		.run(run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.runs_owed(runs_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// run sink: random stall bursts, with calm stretches and none at the end
	initial begin : sink
		int hold;
		bit relaxed;
		relaxed = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) == 0)
				relaxed = !relaxed;
			if (!steady && !relaxed && $urandom_range(0, 5) == 0) begin
				run_ready <= 1'b0;
				hold = $urandom_range(1, 17);
				repeat (hold) @(posedge clk);
			end
			run_ready <= 1'b1;
		end
	end

	function automatic void put_bits(input int v, input int n);
		for (int k = n - 1; k >= 0; k--)
			stream_bits.push_back(v[k]);
	endfunction

	// Append one run of at most cap samples; return the samples it makes.
	function automatic int put_run(input int ed, input int cap);
		int len, lit_cap, k;
		if ($urandom_range(0, 11) == 0) begin
			put_bits(NoopControl, 8);
			return 0;
		end
		if (cap < 2 || $urandom_range(0, 1) == 0) begin
			lit_cap = ($urandom_range(0, 7) == 0) ? 128 : 6;
			if (lit_cap > cap)
				lit_cap = cap;
			len = $urandom_range(1, lit_cap);
			put_bits(len - 1, 8);
			for (k = 0; k < len; k++)
				put_bits($urandom_range(0, (1 << ed) - 1), ed);
		end else begin
			len = $urandom_range(2, (cap < 128) ? cap : 128);
			put_bits(RepeatBase - len, 8);
			put_bits($urandom_range(0, (1 << ed) - 1), ed);
		end
		return len;
	endfunction

	function automatic void build_image(input int ed, input int ec, input image_kind_t kind);
		int left, runs, len, k;
		left = ec;
		case (kind)
			IMG_CLEAN: begin
				while (left > 0)
					left -= put_run(ed, left);
				// trailing bits past the count are ignored
				put_bits($urandom, $urandom_range(0, 12));
			end
			IMG_OVERFLOW: begin
				runs = $urandom_range(0, 3);
				for (k = 0; k < runs && left > 1; k++)
					left -= put_run(ed, left - 1);
				len = $urandom_range(left + 1, 128);
				if ($urandom_range(0, 1) == 0)
					put_bits(len - 1, 8);
				else
					put_bits(RepeatBase - len, 8);
				put_bits($urandom, $urandom_range(0, 20));
			end
			IMG_SHORT: begin
				runs = $urandom_range(0, 4);
				for (k = 0; k < runs && left > 1; k++)
					left -= put_run(ed, left - 1);
				case ($urandom_range(0, 3))
					0: ;
					1: if (left >= 2) begin
						len = $urandom_range(2, (left < 12) ? left : 12);
						put_bits(len - 1, 8);
						for (k = 0; k < len - 1; k++)
							put_bits($urandom_range(0, (1 << ed) - 1), ed);
					end
					2: put_bits($urandom, $urandom_range(1, 7));
					default: if (left >= 2)
						put_bits(RepeatBase - $urandom_range(2, (left < 128) ? left : 128), 8);
				endcase
			end
			default: repeat ($urandom_range(1, 6)) put_bits($urandom, 8);
		endcase
	endfunction

	task automatic send_word(input logic [7:0] b, input logic last);
		if (!steady && !sender_calm && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{stream_byte: b, source_end: last};
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		words_sent++;
		if ($urandom_range(0, 29) == 0)
			sender_calm = !sender_calm;
	endtask

	// Pad the pending bits to whole bytes and send them, marking the last one.
	task automatic ship();
		logic [7:0] b;
		while (stream_bits.size() == 0 || stream_bits.size() % 8 != 0)
			stream_bits.push_back($urandom_range(0, 1));
		while (stream_bits.size() > 0) begin
			for (int k = 0; k < 8; k++)
				b[7 - k] = stream_bits.pop_front();
			send_word(b, stream_bits.size() == 0);
		end
	endtask

	// Hold the sender until every owed run is out and the engine has gone quiet.
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (runs_owed != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CountW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		int cur_depth, cur_count, ed, ec, pick, random_goal;
		image_kind_t kind;
		cur_depth = 8;
		cur_count = 65536;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: literal, longest repeat, no-op, literal cut short by the end mark
		write_reg(CfgSampleDepth, CountW'(DepthMax));
		write_reg(CfgOutputCount, MaxSamples);
		put_bits(8'h00, 8);
		put_bits(8'hFF, 8);
		put_bits(RepeatBase - 128, 8);
		put_bits(8'h00, 8);
		put_bits(NoopControl, 8);
		put_bits(LiteralMax, 8);
		put_bits(8'h5A, 8);
		put_bits(8'hA5, 8);
		ship();

		// depth 1: shortest repeat, then the count is met and junk is dropped
		settle();
		write_reg(CfgSampleDepth, CountW'(1));
		write_reg(CfgOutputCount, CountW'(3));
		put_bits(RepeatBase - 2, 8);
		put_bits(1, 1);
		put_bits(8'h00, 8);
		put_bits(0, 1);
		put_bits(8'hFF, 8);
		ship();

		// run longer than what is left
		settle();
		write_reg(CfgOutputCount, CountW'(2));
		put_bits(8'h02, 8);
		put_bits(8'h3C, 8);
		ship();

		// zero count ends quietly
		settle();
		write_reg(CfgOutputCount, CountW'(0));
		put_bits(8'hFF, 8);
		ship();

		// depth 0 reads as 8, count above the maximum is clamped, source truncated
		settle();
		write_reg(CfgSampleDepth, CountW'(0));
		write_reg(CfgOutputCount, {CountW{1'b1}});
		write_reg(CfgSpareA, {CountW{1'b1}});
		write_reg(CfgSpareB, '0);
		put_bits(8'h01, 8);
		put_bits(8'h12, 8);
		put_bits(8'h34, 8);
		put_bits(8'h00, 8);
		ship();

		// depth above 8 reads as 8, single sample count
		settle();
		write_reg(CfgSampleDepth, CountW'(12));
		write_reg(CfgOutputCount, CountW'(1));
		put_bits(8'h00, 8);
		put_bits(8'h7E, 8);
		put_bits(8'h99, 8);
		ship();
		cur_depth = 12;
		cur_count = 1;

		random_goal = words_sent + RandomWords;
		while (words_sent < random_goal) begin
			settle();
			pick = $urandom_range(0, 5);
			if (pick != 0) begin
				cur_depth = ($urandom_range(0, 9) == 0) ?
					(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15)) :
					$urandom_range(1, 8);
				// upper data bits are junk for the depth register
				write_reg(CfgSampleDepth, {13'($urandom), cur_depth[3:0]});
			end
			if (pick != 1) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					cur_count = 0;
				else if (pick < 14)
					cur_count = $urandom_range(1, 48);
				else if (pick < 17)
					cur_count = $urandom_range(49, 400);
				else
					cur_count = $urandom_range(401, 131071);
				write_reg(CfgOutputCount, CountW'(cur_count));
			end
			if ($urandom_range(0, 9) == 0)
				write_reg(($urandom_range(0, 1) == 0) ? CfgSpareA : CfgSpareB,
					CountW'($urandom));
			ed = (cur_depth == 0 || cur_depth > 8) ? 8 : cur_depth;
			ec = (cur_count > 65536) ? 65536 : cur_count;
			repeat ($urandom_range(1, 3)) begin
				pick = $urandom_range(0, 19);
				if (ec > 400)
					kind = IMG_SHORT;
				else if (pick < 10)
					kind = IMG_CLEAN;
				else if (pick < 13 && ec >= 1 && ec <= 127)
					kind = IMG_OVERFLOW;
				else if (pick < 17 && ec >= 1)
					kind = IMG_SHORT;
				else
					kind = IMG_NOISE;
				build_image(ed, ec, kind);
				ship();
			end
			if (words_sent + 40 >= random_goal)
				steady = 1'b1;
		end

		settle();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
src/vdrle_pkg.sv
src/vdrle_front.sv
src/vdrle_back.sv
src/variable_depth_rle_unpacker.sv
bench/rle_run_checker.sv
bench/variable_depth_rle_unpacker_tb.sv
